// ----- hdl/gda_pkg.sv -----
// Shared types, widths, calendar tables and helper functions of the Gregorian date unit.
package gda_pkg;

   // Default for the largest year that counts as a valid date.
   localparam int unsigned MAX_YEAR_DEF = 9999;

   // Field widths of the request and response items.
   localparam int MODE_W  = 2;
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int COUNT_W = 23;

   // Internal widths: year offset for the search, quotient by 100, day offset in a year,
   // and the day serial number.
   localparam int P_W    = 15;
   localparam int Q_W    = 9;
   localparam int OFFS_W = 9;
   localparam int SER_W  = 24;
   localparam int BIT_W  = 4;

   // Division by 100 as a multiplication by a reciprocal; exact for all P_W-bit values.
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = P_W + 13;

   localparam int DAYS_PER_YEAR = 365;
   localparam int HUNDRED       = 100;
   localparam int MONTHS        = 12;

   // Saturation bounds of the day difference.
   localparam logic signed [SER_W:0] DIFF_MAX = (SER_W+1)'((2 ** (COUNT_W - 1)) - 1);
   localparam logic signed [SER_W:0] DIFF_MIN = -(SER_W+1)'(2 ** (COUNT_W - 1));

   // Operation codes carried in the mode field.
   typedef enum logic [MODE_W-1:0] {
      MODE_ADD  = 2'd0,
      MODE_SUB  = 2'd1,
      MODE_DIFF = 2'd2,
      MODE_CMP  = 2'd3
   } mode_type;

   // Days in each month of a common year; codes that are no month read as zero.
   localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
   };

   // Days of a common year that lie before the first of each month.
   localparam logic [OFFS_W-1:0] DAYS_BEFORE [16] = '{
      9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
   };

   // Quotient of a year offset by 100.
   function automatic logic [Q_W-1:0] div100(input logic [P_W-1:0] v);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(v) * PROD_W'(RECIP_100);
      return prod[RECIP_SHIFT +: Q_W];
   endfunction

   // Leap rule: divisible by 4 and not by 100, or divisible by 400.
   function automatic logic leap_year(input logic [YEAR_W-1:0] y);
      logic [Q_W-1:0] q;
      logic [P_W:0]   h;
      q = div100(P_W'(y));
      h = (P_W+1)'(q) * (P_W+1)'(HUNDRED);
      return (y[1:0] == 2'b00) && ((h != (P_W+1)'(y)) || (q[1:0] == 2'b00));
   endfunction

   // Length of a month, taking February of a leap year into account.
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
      return MONTH_LEN[m] + DAY_W'((m == MONTH_W'(2)) && leap);
   endfunction

   // Days of the year before the first of month m.
   function automatic logic [OFFS_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
      return DAYS_BEFORE[m] + OFFS_W'((m > MONTH_W'(2)) && leap);
   endfunction

endpackage

// ----- hdl/gda_if.sv -----
// Request and response channel interfaces of the Gregorian date unit.
interface gda_req_if;
   import gda_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [MODE_W-1:0]         mode;
   logic [YEAR_W-1:0]         a_year;
   logic [MONTH_W-1:0]        a_month;
   logic [DAY_W-1:0]          a_day;
   logic [YEAR_W-1:0]         b_year;
   logic [MONTH_W-1:0]        b_month;
   logic [DAY_W-1:0]          b_day;
   logic signed [COUNT_W-1:0] day_count;

   modport source (output valid, mode, a_year, a_month, a_day, b_year, b_month, b_day,
                   day_count, input ready);
   modport sink (input valid, mode, a_year, a_month, a_day, b_year, b_month, b_day,
                 day_count, output ready);
endinterface

interface gda_rsp_if;
   import gda_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [YEAR_W-1:0]         result_year;
   logic [MONTH_W-1:0]        result_month;
   logic [DAY_W-1:0]          result_day;
   logic signed [COUNT_W-1:0] day_difference;
   logic                      a_less_than_b;
   logic                      a_equals_b;
   logic                      input_invalid;
   logic                      out_of_range;

   modport source (output valid, result_year, result_month, result_day, day_difference,
                   a_less_than_b, a_equals_b, input_invalid, out_of_range, input ready);
   modport sink (input valid, result_year, result_month, result_day, day_difference,
                 a_less_than_b, a_equals_b, input_invalid, out_of_range, output ready);
endinterface

// ----- hdl/gregorian_date_arithmetic.sv -----
// Top level of the Gregorian date unit: sequencer around a shared year-start unit.
// The unit takes one request at a time and gives exactly one response for it. A request
// adds or subtracts a signed day count to date A, gives the signed days from B to A, or
// only compares A with B; the less and equal flags come with every valid request. Dates
// are converted to day numbers with the year-start unit (one reciprocal multiply, then a
// sum). A shifted date is turned back by a 15-step binary search over the year, each step
// passing through the year-start unit, then stepping through the months one per cycle.
// An add or subtract request whose shifted day lies before the first day of year one ends
// without a search and with the out-of-range flag, and a request with an invalid date
// ends at the check of that date. The request side is ready only between requests; a
// finished response waits in an output register, so the next request can be taken before
// the previous response is read.
module gregorian_date_arithmetic #(
   parameter int unsigned MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
   input logic       clock,
   input logic       reset,
   gda_req_if.sink   req_ch,
   gda_rsp_if.source rsp_ch
);
   import gda_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_LEAP = 7'b0000010,
      S_CHK  = 7'b0000100,
      S_YS0  = 7'b0001000,
      S_YS1  = 7'b0010000,
      S_MON  = 7'b0100000,
      S_FIN  = 7'b1000000
   } state_type;

   localparam logic [YEAR_W-1:0] MaxYear = YEAR_W'(MAX_YEAR);
   localparam logic [P_W-1:0]    MaxP    = P_W'(MAX_YEAR);

   state_type                 state_ff, state_in;
   mode_type                  mode_ff, mode_in;
   logic [YEAR_W-1:0]         b_year_ff, b_year_in;
   logic [MONTH_W-1:0]        b_month_ff, b_month_in;
   logic [DAY_W-1:0]          b_day_ff, b_day_in;
   logic signed [COUNT_W-1:0] cnt_ff, cnt_in;
   logic                      lt_ff, lt_in, eq_ff, eq_in;
   logic                      which_ff, which_in, srch_ff, srch_in;
   logic                      inv_ff, inv_in, oor_ff, oor_in;
   logic [YEAR_W-1:0]         cur_y_ff, cur_y_in;
   logic [MONTH_W-1:0]        cur_m_ff, cur_m_in;
   logic [DAY_W-1:0]          cur_d_ff, cur_d_in;
   logic                      leap_ff;
   logic [P_W-1:0]            p_ff, p_in, base_ff, base_in;
   logic [Q_W-1:0]            q_ff, q_in;
   logic [OFFS_W-1:0]         offs_ff, offs_in;
   logic [SER_W-1:0]          sa_ff, sa_in, s_ff, s_in, ysb_ff, ysb_in;
   logic [BIT_W-1:0]          bit_ff, bit_in;
   logic signed [COUNT_W-1:0] diff_ff, diff_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [YEAR_W-1:0]         out_year_ff, out_year_in;
   logic [MONTH_W-1:0]        out_month_ff, out_month_in;
   logic [DAY_W-1:0]          out_day_ff, out_day_in;
   logic signed [COUNT_W-1:0] out_diff_ff, out_diff_in;
   logic                      out_lt_ff, out_lt_in, out_eq_ff, out_eq_in;
   logic                      out_inv_ff, out_inv_in, out_oor_ff, out_oor_in;

   logic                      req_take, rsp_free;
   logic [SER_W-1:0]          ys, serial;
   logic signed [SER_W:0]     cnt_ext, shifted, diff_full;
   logic                      date_ok, le;
   logic [P_W-1:0]            new_base;
   logic [SER_W-1:0]          new_ysb;
   logic [DAY_W-1:0]          mlen;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && (state_ff == S_IDLE);
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // Shared year-start unit: days before January 1 of year p + 1.
   assign ys = SER_W'(p_ff) * SER_W'(DAYS_PER_YEAR) + SER_W'(p_ff >> 2)
               - SER_W'(q_ff) + SER_W'(q_ff >> 2);
   assign serial = ys + SER_W'(offs_ff);

   // Shifted day number and raw difference.
   assign cnt_ext   = (SER_W+1)'(cnt_ff);
   assign shifted   = (mode_ff == MODE_ADD) ? $signed({1'b0, sa_ff}) + cnt_ext
                                            : $signed({1'b0, sa_ff}) - cnt_ext;
   assign diff_full = $signed({1'b0, sa_ff}) - $signed({1'b0, serial});

   // Date check on the current date, using the leap flag of its year.
   assign mlen    = month_days(cur_m_ff, leap_ff);
   assign date_ok = (cur_y_ff != '0) && (cur_y_ff <= MaxYear)
                    && (cur_m_ff != '0) && (cur_m_ff <= MONTH_W'(MONTHS))
                    && (cur_d_ff != '0) && (cur_d_ff <= mlen);

   // One binary search step: keep the trial year offset when its start is not past s.
   assign le       = (ys <= s_ff);
   assign new_base = le ? p_ff : base_ff;
   assign new_ysb  = le ? ys : ysb_ff;

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      b_year_in  = b_year_ff;
      b_month_in = b_month_ff;
      b_day_in   = b_day_ff;
      cnt_in     = cnt_ff;
      lt_in      = lt_ff;
      eq_in      = eq_ff;
      which_in   = which_ff;
      srch_in    = srch_ff;
      inv_in     = inv_ff;
      oor_in     = oor_ff;
      cur_y_in   = cur_y_ff;
      cur_m_in   = cur_m_ff;
      cur_d_in   = cur_d_ff;
      p_in       = p_ff;
      q_in       = q_ff;
      offs_in    = offs_ff;
      sa_in      = sa_ff;
      s_in       = s_ff;
      base_in    = base_ff;
      ysb_in     = ysb_ff;
      bit_in     = bit_ff;
      diff_in    = diff_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               mode_in    = mode_type'(req_ch.mode);
               b_year_in  = req_ch.b_year;
               b_month_in = req_ch.b_month;
               b_day_in   = req_ch.b_day;
               cnt_in     = req_ch.day_count;
               lt_in      = (req_ch.a_year < req_ch.b_year)
                            || ((req_ch.a_year == req_ch.b_year)
                                && (req_ch.a_month < req_ch.b_month))
                            || ((req_ch.a_year == req_ch.b_year)
                                && (req_ch.a_month == req_ch.b_month)
                                && (req_ch.a_day < req_ch.b_day));
               eq_in      = (req_ch.a_year == req_ch.b_year)
                            && (req_ch.a_month == req_ch.b_month)
                            && (req_ch.a_day == req_ch.b_day);
               cur_y_in   = req_ch.a_year;
               cur_m_in   = req_ch.a_month;
               cur_d_in   = req_ch.a_day;
               which_in   = 1'b0;
               srch_in    = 1'b0;
               inv_in     = 1'b0;
               oor_in     = 1'b0;
               diff_in    = '0;
               state_in   = S_LEAP;
            end
         end
         // The leap flag of the current year settles here.
         S_LEAP: begin
            state_in = srch_ff ? S_MON : S_CHK;
         end
         S_CHK: begin
            if (!date_ok) begin
               inv_in   = 1'b1;
               state_in = S_FIN;
            end else begin
               p_in     = P_W'(cur_y_ff) - P_W'(1);
               offs_in  = days_before(cur_m_ff, leap_ff) + OFFS_W'(cur_d_ff) - OFFS_W'(1);
               state_in = S_YS0;
            end
         end
         S_YS0: begin
            q_in     = div100(p_ff);
            state_in = S_YS1;
         end
         S_YS1: begin
            if (srch_ff) begin
               // Binary search over the year offset, one bit per pass.
               base_in = new_base;
               ysb_in  = new_ysb;
               if (bit_ff == '0) begin
                  if (new_base >= MaxP) begin
                     oor_in   = 1'b1;
                     state_in = S_FIN;
                  end else begin
                     cur_y_in = YEAR_W'(new_base + P_W'(1));
                     cur_m_in = MONTH_W'(1);
                     offs_in  = OFFS_W'(s_ff - new_ysb);
                     state_in = S_LEAP;
                  end
               end else begin
                  bit_in   = bit_ff - BIT_W'(1);
                  p_in     = new_base | (P_W'(1) << (bit_ff - BIT_W'(1)));
                  state_in = S_YS0;
               end
            end else if (!which_ff) begin
               sa_in = serial;
               if (mode_ff == MODE_DIFF || mode_ff == MODE_CMP) begin
                  which_in = 1'b1;
                  cur_y_in = b_year_ff;
                  cur_m_in = b_month_ff;
                  cur_d_in = b_day_ff;
                  state_in = S_LEAP;
               end else begin
                  state_in = S_FIN;
               end
            end else begin
               if (mode_ff == MODE_DIFF) begin
                  if (diff_full > DIFF_MAX) begin
                     diff_in = COUNT_W'(DIFF_MAX);
                  end else if (diff_full < DIFF_MIN) begin
                     diff_in = COUNT_W'(DIFF_MIN);
                  end else begin
                     diff_in = COUNT_W'(diff_full);
                  end
               end
               state_in = S_FIN;
            end
            // A shift request starts the search once the day number of A is known.
            if (!srch_ff && !which_ff
                && (mode_ff == MODE_ADD || mode_ff == MODE_SUB)) begin
               sa_in = serial;
               state_in = S_FIN;
            end
         end
         // Walk through the months of the result year.
         S_MON: begin
            if ((cur_m_ff < MONTH_W'(MONTHS)) && (offs_ff >= OFFS_W'(mlen))) begin
               offs_in  = offs_ff - OFFS_W'(mlen);
               cur_m_in = cur_m_ff + MONTH_W'(1);
            end else begin
               cur_d_in = DAY_W'(offs_ff + OFFS_W'(1));
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // A shift request with a known day number of A goes on to the search.
            if (!inv_ff && !oor_ff && !srch_ff
                && (mode_ff == MODE_ADD || mode_ff == MODE_SUB)) begin
               if (shifted < 0) begin
                  oor_in = 1'b1;
               end else begin
                  srch_in  = 1'b1;
                  s_in     = SER_W'(shifted);
                  base_in  = '0;
                  ysb_in   = '0;
                  bit_in   = BIT_W'(P_W - 1);
                  p_in     = P_W'(1) << (P_W - 1);
                  state_in = S_YS0;
               end
            end else if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response register: loaded when a request finishes and the slot is free.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      out_year_in  = out_year_ff;
      out_month_in = out_month_ff;
      out_day_in   = out_day_ff;
      out_diff_in  = out_diff_ff;
      out_lt_in    = out_lt_ff;
      out_eq_in    = out_eq_ff;
      out_inv_in   = out_inv_ff;
      out_oor_in   = out_oor_ff;
      if ((state_ff == S_FIN) && (state_in == S_IDLE)) begin
         rsp_valid_in = 1'b1;
         out_inv_in   = inv_ff;
         out_lt_in    = lt_ff && !inv_ff;
         out_eq_in    = eq_ff && !inv_ff;
         out_oor_in   = oor_ff && !inv_ff;
         out_diff_in  = inv_ff ? '0 : diff_ff;
         if (!inv_ff && !oor_ff && (mode_ff == MODE_ADD || mode_ff == MODE_SUB)) begin
            out_year_in  = cur_y_ff;
            out_month_in = cur_m_ff;
            out_day_in   = cur_d_ff;
         end else begin
            out_year_in  = '0;
            out_month_in = '0;
            out_day_in   = '0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and response payload registers.
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      b_year_ff    <= b_year_in;
      b_month_ff   <= b_month_in;
      b_day_ff     <= b_day_in;
      cnt_ff       <= cnt_in;
      lt_ff        <= lt_in;
      eq_ff        <= eq_in;
      which_ff     <= which_in;
      srch_ff      <= srch_in;
      inv_ff       <= inv_in;
      oor_ff       <= oor_in;
      cur_y_ff     <= cur_y_in;
      cur_m_ff     <= cur_m_in;
      cur_d_ff     <= cur_d_in;
      leap_ff      <= leap_year(cur_y_ff);
      p_ff         <= p_in;
      q_ff         <= q_in;
      offs_ff      <= offs_in;
      sa_ff        <= sa_in;
      s_ff         <= s_in;
      base_ff      <= base_in;
      ysb_ff       <= ysb_in;
      bit_ff       <= bit_in;
      diff_ff      <= diff_in;
      out_year_ff  <= out_year_in;
      out_month_ff <= out_month_in;
      out_day_ff   <= out_day_in;
      out_diff_ff  <= out_diff_in;
      out_lt_ff    <= out_lt_in;
      out_eq_ff    <= out_eq_in;
      out_inv_ff   <= out_inv_in;
      out_oor_ff   <= out_oor_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.result_year    = out_year_ff;
   assign rsp_ch.result_month   = out_month_ff;
   assign rsp_ch.result_day     = out_day_ff;
   assign rsp_ch.day_difference = out_diff_ff;
   assign rsp_ch.a_less_than_b  = out_lt_ff;
   assign rsp_ch.a_equals_b     = out_eq_ff;
   assign rsp_ch.input_invalid  = out_inv_ff;
   assign rsp_ch.out_of_range   = out_oor_ff;

`ifndef SYNTHESIS
   // An invalid date never comes with any other result field.
   a_inv_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_inv_ff |-> !out_oor_ff && !out_lt_ff && !out_eq_ff
         && (out_diff_ff == '0) && (out_month_ff == '0))
      else $error("invalid response carries result fields");

   // Earlier and identical exclude each other.
   a_cmp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(out_lt_ff && out_eq_ff))
      else $error("less and equal flags both set");

   // A delivered date has a real month and day.
   a_date_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (out_month_ff != '0) |->
         (out_month_ff <= MONTH_W'(MONTHS)) && (out_day_ff != '0) && !out_oor_ff)
      else $error("result date is malformed");

   // The day offset inside the result year stays below one year.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MON) |-> (offs_ff < OFFS_W'(DAYS_PER_YEAR + 1)))
      else $error("day offset exceeds a year");

   // No new request is taken while one is still being worked on.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ch.ready)
      else $error("request accepted while busy");
`endif

endmodule
